// File: hdl/bsr_pkg.sv
// Shared constants, command/status structs and state type for the bisection square root.
package bsr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_STEPS = 40;

    localparam int DATA_W   = 32;
    localparam int STEP_W   = 6;
    localparam int SQ_W     = 2 * DATA_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam logic [DATA_W-1:0] ONE_FIXED = DATA_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_STEPS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_FINISH
    } bsr_state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic step;
        logic publish;
    } bsr_cmd_t;

    typedef struct packed {
        logic trivial;
        logic hit;
        logic at_cap;
        logic out_free;
    } bsr_status_t;

endpackage

// File: hdl/bsr_ctrl.sv
// Controller state machine that sequences load, square, check and publish.
module bsr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  bsr_pkg::bsr_status_t status,
    output bsr_pkg::bsr_cmd_t    cmd
);

    bsr_pkg::bsr_state_t state_reg;
    bsr_pkg::bsr_state_t state_next;
    logic                done;

    assign done = status.trivial | status.hit | status.at_cap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsr_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = bsr_pkg::ST_SQUARE;
                end
            end
            bsr_pkg::ST_SQUARE: begin
                state_next = bsr_pkg::ST_CHECK;
            end
            bsr_pkg::ST_CHECK: begin
                if (done) begin
                    state_next = bsr_pkg::ST_FINISH;
                end else begin
                    state_next = bsr_pkg::ST_SQUARE;
                end
            end
            bsr_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    state_next = bsr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            bsr_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                cmd.load      = s_axis_tvalid;
            end
            bsr_pkg::ST_SQUARE: begin
                cmd.square = 1'b1;
            end
            bsr_pkg::ST_CHECK: begin
                cmd.step = !done;
            end
            bsr_pkg::ST_FINISH: begin
                cmd.publish = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/bsr_dp.sv
// Datapath: interval registers, squaring multiplier, error compare and output register.
module bsr_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [31:0]                      cfg_wdata,
    input  logic [bsr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bsr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  bsr_pkg::bsr_cmd_t                cmd,
    output bsr_pkg::bsr_status_t             status
);

    logic [bsr_pkg::DATA_W-1:0] eps_reg;
    logic [bsr_pkg::DATA_W-1:0] value_reg, value_next;
    logic [bsr_pkg::DATA_W-1:0] lo_reg, lo_next;
    logic [bsr_pkg::DATA_W-1:0] hi_reg, hi_next;
    logic [bsr_pkg::DATA_W-1:0] mid_reg, mid_next;
    logic [bsr_pkg::SQ_W-1:0]   sq_reg, sq_next;
    logic [bsr_pkg::STEP_W-1:0] step_reg, step_next;

    logic [bsr_pkg::DATA_W-1:0] root_reg, root_next;
    logic [bsr_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic                       conv_reg, conv_next;
    logic                       valid_reg, valid_next;

    logic [bsr_pkg::DATA_W-1:0] in_value;
    logic [bsr_pkg::DATA_W-1:0] load_hi;
    logic [bsr_pkg::SQ_W-1:0]   value_scaled;
    logic [bsr_pkg::SQ_W-1:0]   eps_scaled;
    logic [bsr_pkg::SQ_W-1:0]   err;
    logic                       sq_below;
    logic                       trivial;
    logic                       hit;
    logic [bsr_pkg::DATA_W:0]   mid_sum;

    assign in_value = s_axis_tdata[bsr_pkg::DATA_W-1:0];
    assign load_hi  = (in_value < bsr_pkg::ONE_FIXED) ? bsr_pkg::ONE_FIXED : in_value;

    // Square, value and tolerance all sit at 2*FRAC_BITS fraction bits, so the compare is exact.
    assign value_scaled = bsr_pkg::SQ_W'(value_reg) << bsr_pkg::FRAC_BITS;
    assign eps_scaled   = bsr_pkg::SQ_W'(eps_reg) << bsr_pkg::FRAC_BITS;
    assign sq_below     = sq_reg < value_scaled;
    assign err          = sq_below ? (value_scaled - sq_reg) : (sq_reg - value_scaled);
    assign hit          = err <= eps_scaled;
    assign trivial      = (value_reg == '0) || (value_reg == bsr_pkg::ONE_FIXED);

    assign status.trivial  = trivial;
    assign status.hit      = hit;
    assign status.at_cap   = step_reg == bsr_pkg::STEP_LAST;
    assign status.out_free = !valid_reg || m_axis_tready;

    always_comb begin
        value_next = value_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        step_next  = step_reg;
        sq_next    = sq_reg;
        mid_sum    = '0;
        if (cmd.load) begin
            value_next = in_value;
            lo_next    = '0;
            hi_next    = load_hi;
            mid_next   = load_hi >> 1;
            step_next  = '0;
        end
        if (cmd.square) begin
            sq_next = bsr_pkg::SQ_W'(mid_reg) * bsr_pkg::SQ_W'(mid_reg);
        end
        if (cmd.step) begin
            if (sq_below) begin
                lo_next = mid_reg;
                mid_sum = {1'b0, mid_reg} + {1'b0, hi_reg};
            end else begin
                hi_next = mid_reg;
                mid_sum = {1'b0, lo_reg} + {1'b0, mid_reg};
            end
            mid_next  = mid_sum[bsr_pkg::DATA_W:1];
            step_next = step_reg + 1'b1;
        end
    end

    always_comb begin
        root_next  = root_reg;
        steps_next = steps_reg;
        conv_next  = conv_reg;
        valid_next = valid_reg && !m_axis_tready;
        if (cmd.publish) begin
            valid_next = 1'b1;
            if (trivial) begin
                root_next  = value_reg;
                steps_next = '0;
                conv_next  = 1'b1;
            end else begin
                root_next  = mid_reg;
                steps_next = step_reg;
                conv_next  = hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg   <= 32'd6554;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                eps_reg <= cfg_wdata;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        sq_reg    <= sq_next;
        step_reg  <= step_next;
        root_reg  <= root_next;
        steps_reg <= steps_next;
        conv_reg  <= conv_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, conv_reg, steps_reg, root_reg};

endmodule

// File: hdl/bisection_square_root.sv
// An input word loops through squaring and check until it converges, is trivial or reaches the step cap.
// Values 0 and 1.0 are settled at the first check; the cap is the step index MAX_STEPS-1.
// Each bisection step is the 32x32 squaring in ST_SQUARE, then compare and update in ST_CHECK.
// One word at a time: s_axis_tready stays low until the result is written to the output register.
// A finished result waits in the output register while the next input is being worked on.
// Reset (aresetn low, synchronous): controller idle, output empty, epsilon back to 6554.
module bisection_square_root (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [31:0]                      cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // value[31:0]
    input  logic [bsr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // root[31:0], steps[37:32], converged[38], zero pad[39]
    output logic [bsr_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    bsr_pkg::bsr_cmd_t    cmd;
    bsr_pkg::bsr_status_t status;

    bsr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    bsr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// File: hdl/bsr_checker.sv
// Port-level checker for the bisection square root, bound to the top level.
module bsr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bsr_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    // A stalled result word must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed or dropped while stalled");

    // The step index never passes the cap.
    a_steps_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[37:32] <= bsr_pkg::STEP_LAST)
        else $error("step index beyond cap");

    // A result that did not converge must come from the last allowed step.
    a_noconv_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[38] |-> m_axis_tdata[37:32] == bsr_pkg::STEP_LAST)
        else $error("non-converged result before step cap");

    // Once a word is taken the block is busy and its result cannot appear at once.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !$rose(m_axis_tvalid))
        else $error("input taken again or result produced too early");

endmodule

bind bisection_square_root bsr_checker u_bsr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
